// ===== hw/rtl/mlcd_pkg.sv =====
// Shared types and constants for the marker/length/checksum deframer.
// Used by every module of the block; depends on nothing else.

package mlcd_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MARKER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MARKER = 1'b1;

    // Input item function codes.
    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              frame_end;
        logic              checksum_ok;
        logic [WORD_W-1:0] frame_length;
    } result_t;

    // An input item held in the input register.
    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] in_byte;
    } item_t;

endpackage

// ===== hw/rtl/mlcd_in_reg.sv =====
// Input register of the deframer: holds one accepted transfer until the
// frame state machine takes it. Depends on mlcd_pkg.

module mlcd_in_reg
    import mlcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  hold_valid,
    output item_t hold_item,
    input  logic  take
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;

    // The register may refill in the same cycle its content moves on.
    assign in_ready = !hold_valid_reg || take;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (take)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_item_reg <= in_item;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_item  = hold_item_reg;

endmodule

// ===== hw/rtl/mlcd_frame_fsm.sv =====
// Frame state machine of the deframer: marker hunt, header capture and the
// payload checksum. Produces the result of one item combinationally.
// Depends on mlcd_pkg.

module mlcd_frame_fsm
    import mlcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  item_t             item,
    input  logic [BYTE_W-1:0] first_marker,
    input  logic [BYTE_W-1:0] second_marker,
    output logic              has_result,
    output result_t           result
);

    localparam logic [2:0] PH_INIT    = 3'd0;
    localparam logic [2:0] PH_WAIT1   = 3'd1;
    localparam logic [2:0] PH_WAIT2   = 3'd2;
    localparam logic [2:0] PH_LEN1    = 3'd3;
    localparam logic [2:0] PH_LEN2    = 3'd4;
    localparam logic [2:0] PH_CHECK1  = 3'd5;
    localparam logic [2:0] PH_CHECK2  = 3'd6;
    localparam logic [2:0] PH_PROCESS = 3'd7;

    logic [2:0]        phase_reg,          phase_next;
    logic [BYTE_W-1:0] length_low_reg,     length_low_next;
    logic [WORD_W-1:0] payload_length_reg, payload_length_next;
    logic [BYTE_W-1:0] check_low_reg,      check_low_next;
    logic [WORD_W-1:0] expected_sum_reg,   expected_sum_next;
    logic [WORD_W-1:0] running_sum_reg,    running_sum_next;
    logic [WORD_W-1:0] byte_count_reg,     byte_count_next;

    logic [WORD_W-1:0] sum_step;
    logic [WORD_W-1:0] count_step;
    logic              is_payload;
    logic              last;

    // Shift-XOR checksum and byte counter for a payload byte.
    assign sum_step   = {running_sum_reg[WORD_W-2:0], 1'b0} ^ {{(WORD_W-BYTE_W){1'b0}}, item.in_byte};
    assign count_step = byte_count_reg + WORD_W'(1);
    assign is_payload = (payload_length_reg != '0);
    assign last       = (count_step >= payload_length_reg);

    assign has_result = (item.func == FUNC_BYTE) && (phase_reg == PH_PROCESS);

    always_comb
    begin
        result.out_byte     = is_payload ? item.in_byte : '0;
        result.byte_valid   = is_payload;
        result.frame_end    = last;
        result.checksum_ok  = last && (sum_step == expected_sum_reg);
        result.frame_length = last ? payload_length_reg : '0;
    end

    always_comb
    begin
        phase_next          = phase_reg;
        length_low_next     = length_low_reg;
        payload_length_next = payload_length_reg;
        check_low_next      = check_low_reg;
        expected_sum_next   = expected_sum_reg;
        running_sum_next    = running_sum_reg;
        byte_count_next     = byte_count_reg;
        if (item.func == FUNC_RESTART)
        begin
            phase_next = PH_INIT;
        end
        else
        begin
            case (phase_reg)
                PH_INIT:
                begin
                    byte_count_next  = '0;
                    running_sum_next = '0;
                    phase_next = (item.in_byte == first_marker) ? PH_WAIT2 : PH_WAIT1;
                end
                PH_WAIT1:
                begin
                    if (item.in_byte == first_marker)
                    begin
                        phase_next = PH_WAIT2;
                    end
                end
                PH_WAIT2:
                begin
                    phase_next = (item.in_byte == second_marker) ? PH_LEN1 : PH_WAIT1;
                end
                PH_LEN1:
                begin
                    length_low_next = item.in_byte;
                    phase_next      = PH_LEN2;
                end
                PH_LEN2:
                begin
                    payload_length_next = {item.in_byte, length_low_reg};
                    phase_next          = PH_CHECK1;
                end
                PH_CHECK1:
                begin
                    check_low_next = item.in_byte;
                    phase_next     = PH_CHECK2;
                end
                PH_CHECK2:
                begin
                    expected_sum_next = {item.in_byte, check_low_reg};
                    phase_next        = PH_PROCESS;
                end
                default:
                begin
                    running_sum_next = sum_step;
                    byte_count_next  = count_step;
                    if (last)
                    begin
                        phase_next = PH_INIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_INIT;
            length_low_reg     <= '0;
            payload_length_reg <= '0;
            check_low_reg      <= '0;
            expected_sum_reg   <= '0;
            running_sum_reg    <= '0;
            byte_count_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            length_low_reg     <= length_low_next;
            payload_length_reg <= payload_length_next;
            check_low_reg      <= check_low_next;
            expected_sum_reg   <= expected_sum_next;
            running_sum_reg    <= running_sum_next;
            byte_count_reg     <= byte_count_next;
        end
    end

    // A restart always lands in the initial phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.func == FUNC_RESTART) |=> phase_reg == PH_INIT)
        else $error("restart did not return to the initial phase");

    // A frame end sends the machine back to hunting.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && has_result && result.frame_end |=> phase_reg == PH_INIT)
        else $error("frame end did not return to the initial phase");

    // The length is assembled low byte first.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.func == FUNC_BYTE) && (phase_reg == PH_LEN2)
        |=> payload_length_reg == {$past(item.in_byte), $past(length_low_reg)})
        else $error("payload length assembled wrongly");

    // A good verdict is only ever reported on a frame end.
    assert property (@(posedge clk) disable iff (!rst_n)
        has_result && result.checksum_ok |-> result.frame_end)
        else $error("checksum verdict outside a frame end");

endmodule

// ===== hw/rtl/marker_length_checksum_deframer.sv =====
// Top level of the marker/length/checksum deframer: configuration
// registers, input register, frame state machine and result register.
// Depends on mlcd_pkg, mlcd_in_reg and mlcd_frame_fsm.

// The deframer takes one received byte per transfer and hunts for a frame:
// the two marker bytes set through the configuration port, a 16-bit
// payload length and a 16-bit expected checksum (both low byte first), then
// the payload. Each payload byte comes out as one result transfer as soon
// as it is processed; the last one also carries frame_end, the checksum
// verdict and the declared length. A declared length of zero still consumes
// one byte after the header, which yields a single result with byte_valid
// low and frame_end high. Header, marker and restart transfers (func high)
// produce no result. Every transfer is held in the input register and then
// processed by the state machine, whose state update is a short compare plus
// a 16-bit shift-XOR and increment, so the block sustains one transfer per
// clock cycle unless a result waits in the full result register. The result
// register decouples the two sides: while a result waits for out_ready,
// transfers that produce no result keep flowing. Marker registers must be
// written only while the block is idle.

module marker_length_checksum_deframer
    import mlcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    // Input channel.
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [BYTE_W-1:0]    in_byte,
    // Result channel.
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 byte_valid,
    output logic                 frame_end,
    output logic                 checksum_ok,
    output logic [WORD_W-1:0]    frame_length
);

    logic [BYTE_W-1:0] first_marker_reg;
    logic [BYTE_W-1:0] second_marker_reg;

    item_t   in_item;
    item_t   hold_item;
    logic    hold_valid;
    logic    step;
    logic    has_result;
    result_t result;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    logic    load_out;

    // Marker registers, written directly by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_marker_reg  <= '0;
            second_marker_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_MARKER:  first_marker_reg  <= cfg_data;
                CFG_SECOND_MARKER: second_marker_reg <= cfg_data;
                default:           first_marker_reg  <= first_marker_reg;
            endcase
        end
    end

    assign in_item.func    = func;
    assign in_item.in_byte = in_byte;

    mlcd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .hold_valid (hold_valid),
        .hold_item  (hold_item),
        .take       (step)
    );

    // The held transfer is processed when it produces no result, or when
    // the result register is empty or being emptied in this cycle.
    assign step = hold_valid && (!has_result || !out_valid_reg || out_ready);

    mlcd_frame_fsm u_frame_fsm (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (hold_item),
        .first_marker  (first_marker_reg),
        .second_marker (second_marker_reg),
        .has_result    (has_result),
        .result        (result)
    );

    assign load_out = step && has_result;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_data_reg.out_byte;
    assign byte_valid   = out_data_reg.byte_valid;
    assign frame_end    = out_data_reg.frame_end;
    assign checksum_ok  = out_data_reg.checksum_ok;
    assign frame_length = out_data_reg.frame_length;

endmodule

// ===== tb/sv/tb_marker_length_checksum_deframer.sv =====
// Self-checking testbench for the marker/length/checksum deframer.
// Holds its own frame predictor and a scoreboard of expected result transfers.
// Depends on mlcd_pkg and marker_length_checksum_deframer.

module tb_marker_length_checksum_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import mlcd_pkg::*;

    // At least 510 random input transfers (85 per phase), over six marker settings.
    localparam int ITEMS_PER_PHASE = 85;
    localparam int RANDOM_PHASES   = 6;
    // Results to see before the receiver goes quiet for a long stretch.
    localparam int HOLDOFF_AFTER   = 80;
    localparam int HOLDOFF_CYCLES  = 120;

    // Frame hunt states of the predictor, in the order a frame walks them.
    typedef enum logic [2:0] {
        F_START,
        F_HUNT,
        F_SECOND,
        F_LEN_LO,
        F_LEN_HI,
        F_SUM_LO,
        F_SUM_HI,
        F_PAYLOAD
    } frame_state_t;

    // One row of the directed table. Rows with has_typed set carry the
    // result written out by hand; all other rows rely on the predictor.
    typedef struct packed {
        logic    func;
        logic [BYTE_W-1:0] in_byte;
        logic    has_typed;
        result_t typed;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 func;
    logic [BYTE_W-1:0]    in_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [BYTE_W-1:0]    out_byte;
    logic                 byte_valid;
    logic                 frame_end;
    logic                 checksum_ok;
    logic [WORD_W-1:0]    frame_length;

    // Predictor state: marker registers plus a private copy of the frame state.
    logic [BYTE_W-1:0] marker_a;
    logic [BYTE_W-1:0] marker_b;
    frame_state_t      fr_state;
    logic [BYTE_W-1:0] len_lo_q;
    logic [WORD_W-1:0] declared_len;
    logic [BYTE_W-1:0] sum_lo_q;
    logic [WORD_W-1:0] header_sum;
    logic [WORD_W-1:0] payload_sum;
    logic [WORD_W-1:0] payload_count;

    // Result transfers still owed by the block, oldest first.
    result_t expected_results[$];

    int error_count  = 0;
    int results_seen = 0;
    int rx_wait      = 0;
    bit rx_quiet     = 1'b0;
    bit tx_quiet     = 1'b0;

    // Directed table, run with first marker FF and second marker 00.
    // It walks a failed hunt, a second marker that repeats the first one,
    // a zero-length frame with a bad checksum, a restart in the middle of a
    // header with the largest length, and a two-byte frame whose checksum
    // matches.
    dir_row_t directed_rows [23] = '{
        '{FUNC_BYTE,    8'h00, 1'b0, '0},  // no marker in start state: hunt
        '{FUNC_BYTE,    8'hFF, 1'b0, '0},  // first marker
        '{FUNC_BYTE,    8'hFF, 1'b0, '0},  // wrong second marker, back to hunt
        '{FUNC_BYTE,    8'hFF, 1'b0, '0},
        '{FUNC_BYTE,    8'h00, 1'b0, '0},  // second marker
        '{FUNC_BYTE,    8'h00, 1'b0, '0},  // length 0000
        '{FUNC_BYTE,    8'h00, 1'b0, '0},
        '{FUNC_BYTE,    8'h34, 1'b0, '0},  // checksum 1234
        '{FUNC_BYTE,    8'h12, 1'b0, '0},
        // The lone byte of a zero-length frame is not payload.
        '{FUNC_BYTE,    8'h37, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 16'h0000}},
        '{FUNC_BYTE,    8'hFF, 1'b0, '0},  // marker found in start state
        '{FUNC_BYTE,    8'h00, 1'b0, '0},
        '{FUNC_BYTE,    8'hFF, 1'b0, '0},  // length FFFF
        '{FUNC_BYTE,    8'hFF, 1'b0, '0},
        '{FUNC_RESTART, 8'h5A, 1'b0, '0},  // restart drops the frame
        '{FUNC_BYTE,    8'hFF, 1'b0, '0},
        '{FUNC_BYTE,    8'h00, 1'b0, '0},
        '{FUNC_BYTE,    8'h02, 1'b0, '0},  // length 0002
        '{FUNC_BYTE,    8'h00, 1'b0, '0},
        '{FUNC_BYTE,    8'h7E, 1'b0, '0},  // checksum 017E
        '{FUNC_BYTE,    8'h01, 1'b0, '0},
        '{FUNC_BYTE,    8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000}},
        '{FUNC_BYTE,    8'h80, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b1, 16'h0002}}
    };

    marker_length_checksum_deframer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .frame_end    (frame_end),
        .checksum_ok  (checksum_ok),
        .frame_length (frame_length)
    );

    always #2 clk = ~clk;

    // Running frame checksum: shift left one place, then fold in the byte.
    function automatic logic [WORD_W-1:0] fold_checksum(input logic [WORD_W-1:0] sum,
                                                        input logic [BYTE_W-1:0] b);
        return {sum[WORD_W-2:0], 1'b0} ^ {8'h00, b};
    endfunction

    // Advances the predicted frame state by one input transfer. Returns 1
    // when the transfer produces a result, which is then placed in res.
    function automatic bit deframe_step(input logic f, input logic [BYTE_W-1:0] b,
                                        output result_t res);
        bit last;
        res = '0;
        if (f == FUNC_RESTART)
        begin
            fr_state = F_START;
            return 1'b0;
        end
        case (fr_state)
            F_START:
            begin
                // The first byte after a restart opens a fresh checksum,
                // and it can itself be the first marker.
                payload_count = '0;
                payload_sum   = '0;
                fr_state      = (b == marker_a) ? F_SECOND : F_HUNT;
            end
            F_HUNT:
            begin
                if (b == marker_a)
                    fr_state = F_SECOND;
            end
            // A miss here goes back to the hunt without looking at the byte again.
            F_SECOND: fr_state = (b == marker_b) ? F_LEN_LO : F_HUNT;
            F_LEN_LO:
            begin
                len_lo_q = b;
                fr_state = F_LEN_HI;
            end
            F_LEN_HI:
            begin
                declared_len = {b, len_lo_q};
                fr_state     = F_SUM_LO;
            end
            F_SUM_LO:
            begin
                sum_lo_q = b;
                fr_state = F_SUM_HI;
            end
            F_SUM_HI:
            begin
                header_sum = {b, sum_lo_q};
                fr_state   = F_PAYLOAD;
            end
            default:
            begin
                payload_sum   = fold_checksum(payload_sum, b);
                payload_count = payload_count + 16'd1;
                last          = (payload_count >= declared_len);
                // A zero-length frame still eats one byte, but it is not payload.
                if (declared_len != '0)
                begin
                    res.out_byte   = b;
                    res.byte_valid = 1'b1;
                end
                if (last)
                begin
                    res.frame_end    = 1'b1;
                    res.checksum_ok  = (payload_sum == header_sum);
                    res.frame_length = declared_len;
                    fr_state         = F_START;
                end
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Offers one input transfer after a random gap and waits until it is
    // taken. Valid stays high across back-to-back transfers. On acceptance
    // the predictor runs and any result it owes is queued.
    task automatic offer(input logic f, input logic [BYTE_W-1:0] b,
                         input logic has_typed, input result_t typed);
        int      gap;
        bit      made;
        result_t res;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        made = deframe_step(f, b, res);
        if (has_typed)
            expected_results.push_back(typed);
        else if (made)
            expected_results.push_back(res);
    endtask

    // Marker registers change only while the block is idle: every owed
    // result has arrived and any header byte still in the pipeline has
    // had time to retire.
    task automatic program_markers(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_MARKER;
        cfg_data  <= a;
        @(negedge clk);
        cfg_index <= CFG_SECOND_MARKER;
        cfg_data  <= b;
        @(negedge clk);
        cfg_we   <= 1'b0;
        marker_a = a;
        marker_b = b;
    endtask

    // Sender: reset, the directed table, then random traffic under several
    // marker settings, and finally the drain and the verdict.
    initial
    begin
        logic [8:0]        pending[$];
        logic [BYTE_W-1:0] body[$];
        logic [8:0]        item;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] wb;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] chk;
        int                phase_items;
        int                kind;
        int                pick;
        int                start;
        int                cut;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_FIRST_MARKER;
        cfg_data      = '0;
        in_valid      = 1'b0;
        func          = FUNC_BYTE;
        in_byte       = '0;
        marker_a      = '0;
        marker_b      = '0;
        fr_state      = F_START;
        len_lo_q      = '0;
        declared_len  = '0;
        sum_lo_q      = '0;
        header_sum    = '0;
        payload_sum   = '0;
        payload_count = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        program_markers(8'hFF, 8'h00);
        tx_quiet = ($urandom_range(0, 1) == 0);
        foreach (directed_rows[i])
            offer(directed_rows[i].func, directed_rows[i].in_byte,
                  directed_rows[i].has_typed, directed_rows[i].typed);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // Extremes first, equal markers among them, then random pairs.
            case (ph)
                0:
                begin
                    a = 8'h00;
                    b = 8'hFF;
                end
                1:
                begin
                    a = 8'h00;
                    b = 8'h00;
                end
                2:
                begin
                    a = 8'hFF;
                    b = 8'hFF;
                end
                default:
                begin
                    a = 8'($urandom);
                    b = 8'($urandom);
                end
            endcase
            program_markers(a, b);

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                kind     = $urandom_range(0, 99);
                if (kind < 15)
                begin
                    // Line noise, now and then with a restart mixed in.
                    repeat ($urandom_range(1, 6))
                        pending.push_back({($urandom_range(0, 7) == 0) ? FUNC_RESTART
                                                                       : FUNC_BYTE,
                                           8'($urandom)});
                end
                else
                begin
                    // Only a hunting block is sure to lock onto the next
                    // markers, so anything else gets a restart first.
                    if ((fr_state != F_START && fr_state != F_HUNT) ||
                        $urandom_range(0, 3) == 0)
                        pending.push_back({FUNC_RESTART, 8'($urandom)});
                    repeat ($urandom_range(0, 2))
                    begin
                        wb = 8'($urandom);
                        if (wb == marker_a)
                            wb = wb ^ 8'h01;
                        pending.push_back({FUNC_BYTE, wb});
                    end

                    if (kind >= 85 && $urandom_range(0, 1) == 0)
                    begin
                        // Broken marker pair, sometimes the first marker twice.
                        if (marker_a != marker_b && $urandom_range(0, 1) == 0)
                            wb = marker_a;
                        else
                            wb = marker_b ^ (8'h01 << $urandom_range(0, 7));
                        pending.push_back({FUNC_BYTE, marker_a});
                        pending.push_back({FUNC_BYTE, wb});
                    end
                    else
                    begin
                        // Mostly short frames; a few long ones.
                        pick = $urandom_range(0, 99);
                        if (pick < 5)
                            len = '0;
                        else if (pick < 88)
                            len = 16'($urandom_range(1, 8));
                        else if (pick < 97)
                            len = 16'($urandom_range(9, 40));
                        else
                            len = 16'($urandom_range(41, 200));

                        body.delete();
                        sum = '0;
                        repeat ((len == '0) ? 1 : int'(len))
                        begin
                            wb = 8'($urandom);
                            body.push_back(wb);
                            sum = fold_checksum(sum, wb);
                        end
                        chk = ($urandom_range(0, 9) < 6) ? sum : 16'($urandom);

                        start = pending.size();
                        pending.push_back({FUNC_BYTE, marker_a});
                        pending.push_back({FUNC_BYTE, marker_b});
                        pending.push_back({FUNC_BYTE, len[7:0]});
                        pending.push_back({FUNC_BYTE, len[15:8]});
                        pending.push_back({FUNC_BYTE, chk[7:0]});
                        pending.push_back({FUNC_BYTE, chk[15:8]});
                        foreach (body[i])
                            pending.push_back({FUNC_BYTE, body[i]});

                        // Broken frame: cut it anywhere and restart.
                        if (kind >= 85)
                        begin
                            cut = $urandom_range(1, pending.size() - start - 1);
                            while (pending.size() > start + cut)
                                void'(pending.pop_back());
                            pending.push_back({FUNC_RESTART, 8'($urandom)});
                        end
                    end
                end

                phase_items += pending.size();
                while (pending.size() > 0)
                begin
                    item = pending.pop_front();
                    offer(item[8], item[7:0], 1'b0, '0);
                end
            end
        end

        // Drain: every owed result must arrive, and nothing may follow it.
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("marker_length_checksum_deframer: match");
        else
            $display("marker_length_checksum_deframer: mismatch");
        $finish;
    end

    // Receiver: ready drops for a random number of cycles after each
    // transfer, except in quiet stretches. Once, after enough results, it
    // holds off for a long time so that the result register fills and the
    // block has to stall its input.
    initial
    begin
        bit held_off;
        held_off  = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_seen >= HOLDOFF_AFTER)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
            end
            if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Scoreboard: each result transfer is checked field by field against
    // the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        result_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
            if (results_seen % 32 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
            seen = '{out_byte, byte_valid, frame_end, checksum_ok, frame_length};
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %p", seen);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, seen.out_byte);
                    error_count++;
                end
                if (seen.byte_valid !== want.byte_valid)
                begin
                    $error("byte_valid: expected %0b, got %0b",
                           want.byte_valid, seen.byte_valid);
                    error_count++;
                end
                if (seen.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, seen.frame_end);
                    error_count++;
                end
                if (seen.checksum_ok !== want.checksum_ok)
                begin
                    $error("checksum_ok: expected %0b, got %0b",
                           want.checksum_ok, seen.checksum_ok);
                    error_count++;
                end
                if (seen.frame_length !== want.frame_length)
                begin
                    $error("frame_length: expected %0h, got %0h",
                           want.frame_length, seen.frame_length);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(2_000_000);
        $display("marker_length_checksum_deframer: mismatch");
        $finish;
    end

endmodule
